// ===== rtl/psrd_pkg.sv =====
// ----------------------------------------------------------------------------
// psrd_pkg
// Shared types and constants of the pressure setpoint ramp DAC block.
// ----------------------------------------------------------------------------
package psrd_pkg;

    localparam int DIV_NUM_W  = 22;
    localparam int DIV_DEN_W  = 13;

    localparam int PCT_DIV    = 100;
    localparam int MILLI      = 1000;
    localparam int HUNDRED    = 100;
    localparam int CLAMP_MBAR = 1000;
    localparam int LEVEL_MAX  = 4095;
    localparam int STEPS_MAX  = 8191;

    // divide by 100 for values below 2^19: (x * PCT_RECIP) >> PCT_SH
    localparam int PCT_RECIP     = 671089;
    localparam int PCT_RECIP_W   = 20;
    localparam int PCT_SH        = 26;

    // divide by 1000 for values below 2^22: (x * MILLI_RECIP) >> MILLI_SH
    localparam int MILLI_RECIP   = 2147484;
    localparam int MILLI_RECIP_W = 22;
    localparam int MILLI_SH      = 31;

    // divide by 10 for values below 2^22: (x * TEN_RECIP) >> TEN_SH
    localparam int TEN_RECIP     = 6710887;
    localparam int TEN_RECIP_W   = 23;
    localparam int TEN_SH        = 26;

    // divide by 15 for values below 2^20: (x * RECIP_15) >> RECIP_SH
    localparam int RECIP_15   = 1118482;
    localparam int RECIP_W    = 21;
    localparam int RECIP_SH   = 24;

    typedef struct packed {
        logic     set_on;
        logic     set_off;
        logic     tick;
        logic     div_start;
        logic     cap_t;
        logic     cap_s;
        logic     cap_q;
        logic     cap_w;
        logic     out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic steps_nz;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/psrd_if.sv =====
// ----------------------------------------------------------------------------
// psrd_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface psrd_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic        enable;
    logic [10:0] ambient_mbar;
    logic [7:0]  percent;
    logic [15:0] ramp_period_ms;

    modport source (
        output valid, func, enable, ambient_mbar, percent, ramp_period_ms,
        input  ready
    );
    modport sink (
        input  valid, func, enable, ambient_mbar, percent, ramp_period_ms,
        output ready
    );
endinterface

interface psrd_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] dac_code;
    logic [11:0] level_mbar;
    logic [11:0] target_mbar;
    logic        ramp_done;

    modport source (
        output valid, dac_code, level_mbar, target_mbar, ramp_done,
        input  ready
    );
    modport sink (
        input  valid, dac_code, level_mbar, target_mbar, ramp_done,
        output ready
    );
endinterface

// ===== rtl/psrd_div.sv =====
// ----------------------------------------------------------------------------
// psrd_div
// Restoring divider, one quotient bit per cycle, done pulse after the last bit.
// ----------------------------------------------------------------------------
module psrd_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [psrd_pkg::DIV_NUM_W-1:0]   i_dividend,
    input  logic [psrd_pkg::DIV_DEN_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [psrd_pkg::DIV_NUM_W-1:0]   o_quo
);
    localparam int NW  = psrd_pkg::DIV_NUM_W;
    localparam int DW  = psrd_pkg::DIV_DEN_W;
    localparam int CW  = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   shifted;
    logic [DW:0]   trial;

    assign shifted = {r_rem, r_quo[NW-1]};
    assign trial   = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], ~trial[DW]};
            r_rem <= trial[DW] ? shifted[DW-1:0] : trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/psrd_dp.sv =====
// ----------------------------------------------------------------------------
// psrd_dp
// Ramp datapath: target and step setup, step increment through the divider,
// tick stepping, DAC scaling and the result register.
// ----------------------------------------------------------------------------
module psrd_dp #(
    parameter int DAC_BITS = 12,
    parameter int TICK_MS  = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  psrd_pkg::t_ctl_cmd     i_cmd,
    output psrd_pkg::t_dp_status   o_status,
    input  logic [10:0]            i_ambient_mbar,
    input  logic [7:0]             i_percent,
    input  logic [15:0]            i_ramp_period_ms,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [11:0]            o_dac_code,
    output logic [11:0]            o_level_mbar,
    output logic [11:0]            o_target_mbar,
    output logic                   o_ramp_done
);
    localparam int NW     = psrd_pkg::DIV_NUM_W;
    localparam int DW     = psrd_pkg::DIV_DEN_W;
    localparam int CODE_W = DAC_BITS + 1;
    localparam int Y_W    = DAC_BITS + 10;
    localparam int Z_W    = DAC_BITS + 4;
    localparam int P_W    = Z_W + psrd_pkg::RECIP_W;
    localparam logic [CODE_W-1:0] FULL = CODE_W'((1 << DAC_BITS) - 1);
    localparam int T_PW    = 19 + psrd_pkg::PCT_RECIP_W;
    localparam int S_SH    = 16 + $clog2(TICK_MS);
    localparam int S_PW    = S_SH + 16;
    localparam int S_RECIP = ((1 << S_SH) + TICK_MS - 1) / TICK_MS;
    localparam int W_PW    = NW + psrd_pkg::MILLI_RECIP_W;
    localparam int H_PW    = NW + psrd_pkg::TEN_RECIP_W;

    // ramp state
    logic [11:0] r_target;
    logic [15:0] r_ramp;
    logic [11:0] r_whole;
    logic [6:0]  r_frac;
    logic        r_neg;
    logic [6:0]  r_acc;
    logic [12:0] r_steps;
    // setup scratch
    logic [18:0] r_prod;
    logic [15:0] r_period;
    logic [11:0] r_dmag;
    logic [NW-1:0] r_q;
    // tick result
    logic [11:0] r_level;
    logic        r_done;
    // result register
    logic        r_ovalid;
    logic [11:0] r_odac;
    logic [11:0] r_olevel;
    logic [11:0] r_otarget;
    logic        r_odone;

    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic          div_done;
    logic [NW-1:0] div_quo;

    logic [T_PW-1:0] t_prod;
    logic [12:0]     t_quo;
    logic [11:0]     t_sat;
    logic [S_PW-1:0] s_prod;
    logic [15:0]     s_quo;
    logic [12:0]     s_sat;
    logic [W_PW-1:0] w_prod;
    logic [11:0]     w_quo;
    logic [H_PW-1:0] h_prod;
    logic [18:0]     h_quo;
    logic [18:0]     h_diff;
    logic [7:0]  acc_sum;
    logic        carry;
    logic [6:0]  acc_next;
    logic [15:0] step;
    logic [15:0] ramp_next;
    logic [11:0] ramp_clamp;
    logic [9:0]  dac_m;
    logic [Y_W-1:0]    dac_y;
    logic [Z_W-1:0]    dac_z;
    logic [P_W-1:0]    dac_p;
    logic [CODE_W-1:0] dac_raw;
    logic [CODE_W-1:0] dac_sat;

    psrd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    assign div_num = NW'(r_dmag) * NW'(psrd_pkg::MILLI);
    assign div_den = r_steps;

    // constant divisions as reciprocal multiplies
    always_comb begin
        t_prod = T_PW'(r_prod) * T_PW'(psrd_pkg::PCT_RECIP);
        t_quo  = t_prod[psrd_pkg::PCT_SH +: 13];
        t_sat  = (t_quo > 13'(psrd_pkg::LEVEL_MAX)) ? 12'(psrd_pkg::LEVEL_MAX)
                                                    : t_quo[11:0];
        s_prod = S_PW'(r_period) * S_PW'(S_RECIP);
        s_quo  = s_prod[S_SH +: 16];
        priority if (s_quo > 16'(psrd_pkg::STEPS_MAX)) begin
            s_sat = 13'(psrd_pkg::STEPS_MAX);
        end else if (s_quo == '0) begin
            s_sat = 13'd1;
        end else begin
            s_sat = s_quo[12:0];
        end
        w_prod = W_PW'(r_q) * W_PW'(psrd_pkg::MILLI_RECIP);
        w_quo  = w_prod[psrd_pkg::MILLI_SH +: 12];
        h_prod = H_PW'(r_q) * H_PW'(psrd_pkg::TEN_RECIP);
        h_quo  = h_prod[psrd_pkg::TEN_SH +: 19];
        h_diff = h_quo - 19'(w_quo) * 19'(psrd_pkg::HUNDRED);
    end

    // tick stepping with hundredths carry
    always_comb begin
        acc_sum    = {1'b0, r_acc} + {1'b0, r_frac};
        carry      = (acc_sum >= 8'(psrd_pkg::HUNDRED));
        acc_next   = carry ? 7'(acc_sum - 8'(psrd_pkg::HUNDRED)) : acc_sum[6:0];
        step       = 16'(r_whole) + 16'(carry);
        ramp_next  = r_neg ? (r_ramp - step) : (r_ramp + step);
        ramp_clamp = (r_ramp > 16'(psrd_pkg::LEVEL_MAX)) ? 12'(psrd_pkg::LEVEL_MAX)
                                                         : r_ramp[11:0];
    end

    // code = min(level, 1000) * full / 960, full * m as a shift and subtract
    always_comb begin
        dac_m   = (r_level > 12'(psrd_pkg::CLAMP_MBAR)) ? 10'(psrd_pkg::CLAMP_MBAR)
                                                        : r_level[9:0];
        dac_y   = {dac_m, {DAC_BITS{1'b0}}} - Y_W'(dac_m);
        dac_z   = dac_y[Y_W-1:6];
        dac_p   = P_W'(dac_z) * P_W'(psrd_pkg::RECIP_15);
        dac_raw = dac_p[P_W-1:psrd_pkg::RECIP_SH];
        dac_sat = (dac_raw > FULL) ? FULL : dac_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_ramp   <= '0;
            r_whole  <= '0;
            r_frac   <= '0;
            r_neg    <= 1'b0;
            r_acc    <= '0;
            r_steps  <= '0;
        end else begin
            if (i_cmd.set_off) begin
                r_target <= '0;
                r_whole  <= '0;
                r_frac   <= '0;
                r_steps  <= 13'd1;
            end
            if (i_cmd.cap_t) begin
                r_ramp   <= 16'(r_target);
                r_target <= t_sat;
            end
            if (i_cmd.cap_s) begin
                r_steps <= s_sat;
                r_neg   <= (r_target < r_ramp[11:0]);
            end
            if (i_cmd.cap_w) begin
                r_whole <= w_quo;
                r_frac  <= h_diff[6:0];
                r_acc   <= '0;
            end
            if (i_cmd.tick && (r_steps != '0)) begin
                r_steps <= r_steps - 1'b1;
                if (r_steps != 13'd1) begin
                    r_acc  <= acc_next;
                    r_ramp <= ramp_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_on) begin
            r_prod   <= 19'(i_ambient_mbar) * 19'(i_percent);
            r_period <= i_ramp_period_ms;
        end
        if (i_cmd.cap_s) begin
            r_dmag <= (r_target >= r_ramp[11:0]) ? (r_target - r_ramp[11:0])
                                                 : (r_ramp[11:0] - r_target);
        end
        if (i_cmd.cap_q) begin
            r_q <= div_quo;
        end
        if (i_cmd.tick) begin
            r_done  <= (r_steps == 13'd1);
            r_level <= (r_steps == 13'd1) ? r_target : ramp_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odac    <= 12'(dac_sat);
            r_olevel  <= r_level;
            r_otarget <= r_target;
            r_odone   <= r_done;
        end
    end

    assign o_status.steps_nz = (r_steps != '0);
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid   = r_ovalid;
    assign o_dac_code    = r_odac;
    assign o_level_mbar  = r_olevel;
    assign o_target_mbar = r_otarget;
    assign o_ramp_done   = r_odone;

endmodule

// ===== rtl/psrd_ctl.sv =====
// ----------------------------------------------------------------------------
// psrd_ctl
// Sequencer: accepts beats, runs the ramp setup around the step division and
// the tick output.
// ----------------------------------------------------------------------------
module psrd_ctl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_func,
    input  logic                   i_enable,
    output logic                   o_ready,
    input  psrd_pkg::t_dp_status   i_status,
    output psrd_pkg::t_ctl_cmd     o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DT   = 6'b000010,
        S_DS   = 6'b000100,
        S_DQ   = 6'b001000,
        S_DW   = 6'b010000,
        S_OUT  = 6'b100000
    } t_ctl_state;

    t_ctl_state r_state;
    t_ctl_state n_state;
    logic       r_start;
    logic       n_start;
    logic       accept;

    assign o_ready = (r_state == S_IDLE) && i_status.out_free;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_start = 1'b0;
        o_cmd   = '0;
        o_cmd.div_start = r_start;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func && i_enable) begin
                        o_cmd.set_on = 1'b1;
                        n_state      = S_DT;
                    end else if (i_func) begin
                        o_cmd.set_off = 1'b1;
                    end else begin
                        o_cmd.tick = 1'b1;
                        if (i_status.steps_nz) begin
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_DT: begin
                o_cmd.cap_t = 1'b1;
                n_state     = S_DS;
            end
            S_DS: begin
                o_cmd.cap_s = 1'b1;
                n_state     = S_DQ;
                n_start     = 1'b1;
            end
            S_DQ: begin
                if (i_status.div_done) begin
                    o_cmd.cap_q = 1'b1;
                    n_state     = S_DW;
                end
            end
            S_DW: begin
                o_cmd.cap_w = 1'b1;
                n_state     = S_IDLE;
            end
            S_OUT: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
        end
    end

endmodule

// ===== rtl/pressure_setpoint_ramp_dac.sv =====
// ----------------------------------------------------------------------------
// pressure_setpoint_ramp_dac
// Linear pressure setpoint ramp with per-tick DAC code output.
//
//   channel   dir   beat contents
//   i_cmd     in    func, enable, ambient_mbar, percent, ramp_period_ms
//   o_res     out   dac_code, level_mbar, target_mbar, ramp_done
//
// a tick beat runs the step update, then DAC scaling into the result register;
// a tick with no step pending gives no beat
// a set beat with enable runs target and step count setup, a pass through
// the restoring divider for the step increment, then the whole and
// hundredths split; a set beat without enable clears target and step increment
// i_cmd.ready is low while a set or tick is in progress or an output is unread
// synchronous active-low reset clears the ramp state and result valid register
// ----------------------------------------------------------------------------
module pressure_setpoint_ramp_dac #(
    parameter int DAC_BITS = 12,
    parameter int TICK_MS  = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psrd_in_if.sink     i_cmd,
    psrd_out_if.source  o_res
);
    psrd_pkg::t_ctl_cmd   cmd;
    psrd_pkg::t_dp_status status;
    logic                 ready;

    psrd_ctl u_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_cmd.valid),
        .i_func   (i_cmd.func),
        .i_enable (i_cmd.enable),
        .o_ready  (ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    psrd_dp #(
        .DAC_BITS (DAC_BITS),
        .TICK_MS  (TICK_MS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_ambient_mbar   (i_cmd.ambient_mbar),
        .i_percent        (i_cmd.percent),
        .i_ramp_period_ms (i_cmd.ramp_period_ms),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_dac_code       (o_res.dac_code),
        .o_level_mbar     (o_res.level_mbar),
        .o_target_mbar    (o_res.target_mbar),
        .o_ramp_done      (o_res.ramp_done)
    );

    assign i_cmd.ready = ready;

    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ready |-> !(o_res.valid && !o_res.ready))
        else $error("command ready while result register is blocked");

    a_set_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && i_cmd.func && i_cmd.enable) |=> !i_cmd.ready)
        else $error("ready during ramp setup");

    a_done_at_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ramp_done) |-> (o_res.level_mbar == o_res.target_mbar))
        else $error("final beat level differs from target");

    a_dac_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.level_mbar >= 12'd960))
            |-> ((DAC_BITS != 12) || (o_res.dac_code == 12'hFFF)))
        else $error("dac code not at full scale above 960 mbar");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pressure setpoint ramp DAC. Command beats (sets
// and ticks) come from a queue. Each accepted beat runs through a bit-accurate
// ramp predictor, and result beats are checked in order against its output.
// The run goes through phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import psrd_pkg::*;

    localparam int N_ITEMS      = 550;
    localparam int N_PHASES     = 4;
    localparam int WD_LIMIT     = 4000;
    localparam int DRAIN_CYCLES = 150;

    localparam int TICK_MS   = 10;
    localparam int DAC_FULL  = (1 << 12) - 1;
    localparam int DPR_SPAN  = 960;

    localparam bit FUNC_TICK = 1'b0;
    localparam bit FUNC_SET  = 1'b1;
    localparam bit REG_OFF   = 1'b0;
    localparam bit REG_ON    = 1'b1;

    typedef struct {
        bit        func;
        bit        enable;
        bit [10:0] ambient_mbar;
        bit [7:0]  percent;
        bit [15:0] ramp_period_ms;
    } cmd_beat_t;

    typedef struct {
        bit [11:0] dac_code;
        bit [11:0] level_mbar;
        bit [11:0] target_mbar;
        bit        ramp_done;
    } dac_beat_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    psrd_in_if  cmd_if ();
    psrd_out_if res_if ();

    pressure_setpoint_ramp_dac u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    cmd_beat_t pending_cmds[$];
    dac_beat_t expected_dac[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int err_cnt        = 0;
    int idle_cycles    = 0;
    bit cmd_fire       = 1'b0;

    // predicted ramp state
    bit [11:0] pr_target = '0;
    bit [15:0] pr_ramp   = '0;
    int        pr_incr   = 0;
    bit [6:0]  pr_frac   = '0;
    bit [12:0] pr_steps  = '0;

    // stimulus side view of the pending step count
    int gen_steps = 0;
    int gen_items = 0;

    function automatic int dac_code_of(int mbar);
        int code;
        if (mbar > CLAMP_MBAR)
            mbar = CLAMP_MBAR;
        code = mbar * DAC_FULL / DPR_SPAN;
        if (code > DAC_FULL)
            code = DAC_FULL;
        return code;
    endfunction

    task automatic predict_setpoint(input cmd_beat_t c);
        int        t;
        int        s;
        int        diff;
        int        mag;
        int        whole;
        int        acc;
        int        lv;
        dac_beat_t r;
        if (c.func == FUNC_SET) begin
            if (c.enable == REG_OFF) begin
                pr_target = '0;
                pr_incr   = 0;
                pr_steps  = 13'd1;
            end else begin
                t = int'(c.ambient_mbar) * int'(c.percent) / PCT_DIV;
                s = int'(c.ramp_period_ms) / TICK_MS;
                if (t > LEVEL_MAX)
                    t = LEVEL_MAX;
                if (s > STEPS_MAX)
                    s = STEPS_MAX;
                if (s == 0)
                    s = 1;
                pr_ramp   = 16'(pr_target);
                pr_target = 12'(t);
                diff      = t - int'(pr_ramp);
                pr_incr   = diff * MILLI / s;
                pr_frac   = '0;
                pr_steps  = 13'(s);
            end
        end else if (pr_steps != 0) begin
            pr_steps = pr_steps - 13'd1;
            if (pr_steps == 0) begin
                lv          = int'(pr_target);
                r.ramp_done = 1'b1;
            end else begin
                lv          = int'(pr_ramp);
                r.ramp_done = 1'b0;
                mag   = (pr_incr < 0) ? -pr_incr : pr_incr;
                whole = mag / MILLI;
                // hundredths digit of the step, carried separately
                acc   = int'(pr_frac) + (mag / (MILLI / HUNDRED)) % HUNDRED;
                if (acc >= HUNDRED) begin
                    acc   = acc - HUNDRED;
                    whole = whole + 1;
                end
                pr_frac = 7'(acc);
                if (pr_incr < 0)
                    pr_ramp = pr_ramp - 16'(whole);
                else
                    pr_ramp = pr_ramp + 16'(whole);
            end
            if (lv > LEVEL_MAX)
                lv = LEVEL_MAX;
            r.dac_code    = 12'(dac_code_of(lv));
            r.level_mbar  = 12'(lv);
            r.target_mbar = pr_target;
            expected_dac.push_back(r);
        end
    endtask

    task automatic queue_cmd(input bit func, input bit en, input int amb, input int pct,
                             input int per);
        cmd_beat_t c;
        int        s;
        c.func           = func;
        c.enable         = en;
        c.ambient_mbar   = 11'(amb);
        c.percent        = 8'(pct);
        c.ramp_period_ms = 16'(per);
        if (func == FUNC_SET) begin
            gen_items++;
            s = per / TICK_MS;
            if (s > STEPS_MAX)
                s = STEPS_MAX;
            if (s == 0)
                s = 1;
            gen_steps = (en == REG_ON) ? s : 1;
        end else if (gen_steps > 0) begin
            gen_items++;
            gen_steps--;
        end
        pending_cmds.push_back(c);
    endtask

    task automatic queue_ticks(input int n);
        repeat (n)
            queue_cmd(FUNC_TICK, 1'($urandom_range(1)), $urandom_range(2047),
                      $urandom_range(255), $urandom_range(65535));
    endtask

    task automatic queue_random_sequence();
        int sel;
        int amb;
        int pct;
        int per;
        int n;
        sel = $urandom_range(99);
        case ($urandom_range(9))
            0: amb = 0;
            1: amb = 2047;
            default: amb = $urandom_range(2047);
        endcase
        case ($urandom_range(19))
            0: pct = 0;
            1: pct = 200;
            2: pct = $urandom_range(255, 201);
            default: pct = $urandom_range(200);
        endcase
        case ($urandom_range(19))
            0: per = $urandom_range(65535);
            1, 2, 3: per = $urandom_range(3000, 400);
            4: per = $urandom_range(9);
            default: per = $urandom_range(400, 10);
        endcase
        if (sel < 70) begin
            queue_cmd(FUNC_SET, REG_ON, amb, pct, per);
            n = gen_steps;
            if (n > 300)
                queue_ticks($urandom_range(40, 5));
            else if ($urandom_range(4) != 0)
                queue_ticks(n + $urandom_range(2));
            else
                queue_ticks($urandom_range(n));
        end else if (sel < 82) begin
            queue_cmd(FUNC_SET, REG_OFF, amb, pct, per);
            queue_ticks($urandom_range(2, 1));
        end else if (sel < 91) begin
            queue_ticks(1);
        end else begin
            queue_cmd(FUNC_SET, 1'($urandom_range(1)), $urandom_range(2047),
                      $urandom_range(255), $urandom_range(65535));
        end
    endtask

    // command driver and receiver ready
    always @(negedge i_clk) begin : cmd_drive
        cmd_beat_t c;
        bit        load;
        if (i_rst_n) begin
            if (!cmd_if.valid || cmd_fire) begin
                load = (pending_cmds.size() > 0) && ($urandom_range(99) >= send_idle_pct);
                if (load) begin
                    c = pending_cmds.pop_front();
                    cmd_if.func           <= c.func;
                    cmd_if.enable         <= c.enable;
                    cmd_if.ambient_mbar   <= c.ambient_mbar;
                    cmd_if.percent        <= c.percent;
                    cmd_if.ramp_period_ms <= c.ramp_period_ms;
                end
                cmd_if.valid <= load;
            end
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // beat monitor and checker
    always @(posedge i_clk) begin : beat_mon
        cmd_beat_t c;
        dac_beat_t want;
        bit        cmd_beat;
        bit        res_beat;
        cmd_beat = i_rst_n && cmd_if.valid && cmd_if.ready;
        res_beat = i_rst_n && res_if.valid && res_if.ready;
        cmd_fire    <= cmd_beat;
        idle_cycles <= (cmd_beat || res_beat) ? 0 : idle_cycles + 1;
        if (cmd_beat) begin
            c.func           = cmd_if.func;
            c.enable         = cmd_if.enable;
            c.ambient_mbar   = cmd_if.ambient_mbar;
            c.percent        = cmd_if.percent;
            c.ramp_period_ms = cmd_if.ramp_period_ms;
            predict_setpoint(c);
        end
        if (res_beat) begin
            if (expected_dac.size() == 0) begin
                $error("unexpected result beat: dac_code %0d level_mbar %0d",
                       res_if.dac_code, res_if.level_mbar);
                err_cnt++;
            end else begin
                want = expected_dac.pop_front();
                if (res_if.dac_code !== want.dac_code) begin
                    $error("dac_code: expected %0d, got %0d", want.dac_code, res_if.dac_code);
                    err_cnt++;
                end
                if (res_if.level_mbar !== want.level_mbar) begin
                    $error("level_mbar: expected %0d, got %0d", want.level_mbar,
                           res_if.level_mbar);
                    err_cnt++;
                end
                if (res_if.target_mbar !== want.target_mbar) begin
                    $error("target_mbar: expected %0d, got %0d", want.target_mbar,
                           res_if.target_mbar);
                    err_cnt++;
                end
                if (res_if.ramp_done !== want.ramp_done) begin
                    $error("ramp_done: expected %0d, got %0d", want.ramp_done,
                           res_if.ramp_done);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < WD_LIMIT)
            @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int phase;
        cmd_if.valid          = 1'b0;
        cmd_if.func           = 1'b0;
        cmd_if.enable         = 1'b0;
        cmd_if.ambient_mbar   = '0;
        cmd_if.percent        = '0;
        cmd_if.ramp_period_ms = '0;
        res_if.ready          = 1'b0;

        // nothing pending
        queue_ticks(1);
        // target saturates, period below one tick, dac clamp
        queue_cmd(FUNC_SET, REG_ON, 2047, 255, 0);
        queue_ticks(1);
        // falling ramp with a hundredths carry
        queue_cmd(FUNC_SET, REG_ON, 0, 0, 60);
        queue_ticks(6);
        // regulator off
        queue_cmd(FUNC_SET, REG_OFF, 1013, 100, 500);
        queue_ticks(2);
        // longest ramp period, step count stays below saturation
        queue_cmd(FUNC_SET, REG_ON, 1000, 100, 65535);
        queue_ticks(2);
        // interrupted long ramp, then short period
        queue_cmd(FUNC_SET, REG_ON, 1500, 199, 9);
        queue_ticks(1);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            while (gen_items < (phase + 1) * N_ITEMS / N_PHASES)
                queue_random_sequence();
            // hold off until the block has drained
            while (pending_cmds.size() != 0 || cmd_if.valid || expected_dac.size() != 0)
                @(negedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && expected_dac.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
